### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ATS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ATS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ATS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Field widths, register indexes, reset values and the command and status
// groups shared by the altitude statistics controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    localparam int ALT_W      = 25;
    localparam int HYST_W     = 20;
    localparam int WLEN_W     = 7;
    localparam int TOTAL_W    = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS = 2'd1;

    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET = 7'd60;
    localparam logic [HYST_W-1:0] HYSTERESIS_RESET = 20'd10000;

    // controller to datapath
    typedef struct packed {
        logic load;       // transaction accepted: store sample, update marks
        logic rd_issue;   // read next older window entry
        logic acc;        // add read data to the window sum
        logic div_start;  // load divider, apply climb/drop totals
        logic div_step;   // one restoring division step
        logic out_load;   // move result into the output register
    } ats_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic rd_done;    // all window entries read
        logic div_done;   // all quotient bits produced
    } ats_sts_t;

endpackage

`default_nettype wire

### rtl/ats_ctrl.sv
// ----------------------------------------------------------------------------
// ats_ctrl
// Sequencer: accept a sample, sweep the window, run the divider, then hand
// the result to the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ats_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire ats_pkg::ats_sts_t sts,
    output ats_pkg::ats_cmd_t     cmd
);
    import ats_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   acc_pend_reg;
    logic   acc_pend_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_issue = !sts.rd_done;
                cmd.acc      = acc_pend_reg;
                if (sts.rd_done && !acc_pend_reg)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_FINISH;
                else
                    cmd.div_step = 1'b1;
            end
            ST_FINISH:
            begin
                // hold until the previous result has been taken
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read data is registered, so it returns in the cycle after the read is issued
    assign acc_pend_next  = cmd.rd_issue;
    assign out_valid_next = cmd.out_load | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_pend_reg  <= acc_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `ATS_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.load, cmd.rd_issue, cmd.div_start, cmd.div_step, cmd.out_load}), "ats_ctrl: overlapping commands")
    `ATS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !(out_valid_reg && out_stall), "ats_ctrl: result overwritten while held")
    `ATS_ASSERT_NXT(a_issue_then_acc, cmd.rd_issue, cmd.acc, "ats_ctrl: read data not accumulated")

endmodule

`default_nettype wire

### rtl/ats_dp.sv
// ----------------------------------------------------------------------------
// ats_dp
// Datapath: sample ring memory, window sum, restoring divider for the floor
// mean, low/high marks, hysteresis tracking and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ats_dp #(
    parameter int MAX_WINDOW = 64
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ats_pkg::ats_cmd_t                    cmd,
    output ats_pkg::ats_sts_t                         sts,
    input  wire logic [ats_pkg::WLEN_W-1:0]           window_len,
    input  wire logic [ats_pkg::HYST_W-1:0]           hysteresis,
    input  wire logic signed [ats_pkg::ALT_W-1:0]     altitude,
    output logic signed [ats_pkg::ALT_W-1:0]          current_alt,
    output logic signed [ats_pkg::ALT_W-1:0]          mean_alt,
    output logic signed [ats_pkg::ALT_W-1:0]          lowest_alt,
    output logic signed [ats_pkg::ALT_W-1:0]          highest_alt,
    output logic [ats_pkg::TOTAL_W-1:0]               total_ascent,
    output logic [ats_pkg::TOTAL_W-1:0]               total_descent
);
    import ats_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = ALT_W + CNT_W;
    localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int REM_W = CNT_W + 1;
    localparam int DC_W  = $clog2(SUM_W + 1);

    // sample ring
    logic signed [ALT_W-1:0] mem [MAX_WINDOW];
    logic signed [ALT_W-1:0] rd_data_reg;

    logic [PTR_W-1:0]        wr_ptr_reg;
    logic [PTR_W-1:0]        wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg;
    logic [PTR_W-1:0]        rd_ptr_dec;
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;
    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        n_next;
    logic [CNT_W-1:0]        rd_left_reg;
    logic [LEN_W-1:0]        len_ext;
    logic [LEN_W-1:0]        eff_len;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0]        sum_u;
    logic [SUM_W-1:0]        sum_mag;

    // divider
    logic [SUM_W-1:0]        quo_reg;
    logic [REM_W-1:0]        rem_reg;
    logic                    neg_reg;
    logic [DC_W-1:0]         div_cnt_reg;
    logic [REM_W-1:0]        rem_shift;
    logic [REM_W-1:0]        n_ext;
    logic                    quo_bit;
    logic [REM_W-1:0]        rem_step;
    logic [SUM_W-1:0]        mean_full;

    // marks and climb tracking
    logic signed [ALT_W-1:0] alt_reg;
    logic signed [ALT_W-1:0] low_reg;
    logic signed [ALT_W-1:0] high_reg;
    logic signed [ALT_W-1:0] ref_reg;
    logic                    seen_reg;
    logic signed [ALT_W:0]   alt_x;
    logic signed [ALT_W:0]   ref_x;
    logic signed [ALT_W:0]   delta_load;
    logic signed [ALT_W:0]   delta_reg;
    logic signed [ALT_W:0]   neg_delta;
    logic signed [ALT_W:0]   hyst_s;
    logic                    climb;
    logic                    drop;
    logic [TOTAL_W-1:0]      climb_reg;
    logic [TOTAL_W-1:0]      drop_reg;
    logic [TOTAL_W:0]        climb_sum;
    logic [TOTAL_W:0]        drop_sum;
    logic [TOTAL_W-1:0]      climb_sat;
    logic [TOTAL_W-1:0]      drop_sat;

    // output register
    logic signed [ALT_W-1:0] cur_out_reg;
    logic signed [ALT_W-1:0] mean_out_reg;
    logic signed [ALT_W-1:0] low_out_reg;
    logic signed [ALT_W-1:0] high_out_reg;
    logic [TOTAL_W-1:0]      asc_out_reg;
    logic [TOTAL_W-1:0]      dsc_out_reg;

    // window bookkeeping
    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(MAX_WINDOW - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_dec  = (rd_ptr_reg == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_ptr_reg - 1'b1;
    assign fill_next   = (fill_reg == CNT_W'(MAX_WINDOW)) ? fill_reg : fill_reg + 1'b1;

    // zero length counts as one, clamp to the ring size
    assign len_ext = LEN_W'(window_len);

    always_comb
    begin
        if (len_ext == '0)
            eff_len = LEN_W'(1);
        else if (len_ext > LEN_W'(MAX_WINDOW))
            eff_len = LEN_W'(MAX_WINDOW);
        else
            eff_len = len_ext;
    end

    assign n_next = (LEN_W'(fill_next) < eff_len) ? fill_next : eff_len[CNT_W-1:0];

    // sum magnitude for the unsigned divider
    assign sum_u   = $unsigned(sum_reg);
    assign sum_mag = sum_reg[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

    assign rem_shift = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};
    assign n_ext     = REM_W'(n_reg);
    assign quo_bit   = (rem_shift >= n_ext);
    assign rem_step  = quo_bit ? (rem_shift - n_ext) : rem_shift;

    // floor toward minus infinity: -q - 1 is ~q when a remainder is left
    always_comb
    begin
        if (!neg_reg)
            mean_full = quo_reg;
        else if (rem_reg != '0)
            mean_full = ~quo_reg;
        else
            mean_full = ~quo_reg + 1'b1;
    end

    // climb and drop against the reference
    assign alt_x      = {altitude[ALT_W-1], altitude};
    assign ref_x      = {ref_reg[ALT_W-1], ref_reg};
    assign delta_load = seen_reg ? (alt_x - ref_x) : '0;
    assign neg_delta  = -delta_reg;
    assign hyst_s     = {{(ALT_W + 1 - HYST_W){1'b0}}, hysteresis};
    assign climb      = (delta_reg > hyst_s);
    assign drop       = (neg_delta > hyst_s);
    assign climb_sum  = {1'b0, climb_reg} + (TOTAL_W + 1)'(delta_reg[ALT_W-1:0]);
    assign drop_sum   = {1'b0, drop_reg} + (TOTAL_W + 1)'(neg_delta[ALT_W-1:0]);
    assign climb_sat  = climb_sum[TOTAL_W] ? '1 : climb_sum[TOTAL_W-1:0];
    assign drop_sat   = drop_sum[TOTAL_W] ? '1 : drop_sum[TOTAL_W-1:0];

    // ring memory: write on accept, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            mem[wr_ptr_reg] <= altitude;
        if (cmd.rd_issue)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    // state with a defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            rd_left_reg <= '0;
            div_cnt_reg <= '0;
            seen_reg    <= 1'b0;
            low_reg     <= '0;
            high_reg    <= '0;
            ref_reg     <= '0;
            climb_reg   <= '0;
            drop_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                wr_ptr_reg  <= wr_ptr_next;
                fill_reg    <= fill_next;
                rd_left_reg <= n_next;
                seen_reg    <= 1'b1;
                if (!seen_reg)
                begin
                    low_reg   <= altitude;
                    high_reg  <= altitude;
                    ref_reg   <= altitude;
                    climb_reg <= '0;
                    drop_reg  <= '0;
                end
                else
                begin
                    if (altitude < low_reg)
                        low_reg <= altitude;
                    if (altitude > high_reg)
                        high_reg <= altitude;
                end
            end
            if (cmd.rd_issue)
                rd_left_reg <= rd_left_reg - 1'b1;
            if (cmd.div_start)
            begin
                div_cnt_reg <= DC_W'(SUM_W);
                if (climb)
                begin
                    climb_reg <= climb_sat;
                    ref_reg   <= alt_reg;
                end
                else if (drop)
                begin
                    drop_reg <= drop_sat;
                    ref_reg  <= alt_reg;
                end
            end
            if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            alt_reg    <= altitude;
            delta_reg  <= delta_load;
            n_reg      <= n_next;
            rd_ptr_reg <= wr_ptr_reg;
            sum_reg    <= '0;
        end
        if (cmd.rd_issue)
            rd_ptr_reg <= rd_ptr_dec;
        if (cmd.acc)
            sum_reg <= sum_reg + {{(SUM_W - ALT_W){rd_data_reg[ALT_W-1]}}, rd_data_reg};
        if (cmd.div_start)
        begin
            quo_reg <= sum_mag;
            rem_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], quo_bit};
            rem_reg <= rem_step;
        end
        if (cmd.out_load)
        begin
            cur_out_reg  <= alt_reg;
            mean_out_reg <= mean_full[ALT_W-1:0];
            low_out_reg  <= low_reg;
            high_out_reg <= high_reg;
            asc_out_reg  <= climb_reg;
            dsc_out_reg  <= drop_reg;
        end
    end

    assign sts.rd_done  = (rd_left_reg == '0);
    assign sts.div_done = (div_cnt_reg == '0);

    assign current_alt   = cur_out_reg;
    assign mean_alt      = mean_out_reg;
    assign lowest_alt    = low_out_reg;
    assign highest_alt   = high_out_reg;
    assign total_ascent  = asc_out_reg;
    assign total_descent = dsc_out_reg;

    `ATS_ASSERT_IMP(a_read_bound, cmd.rd_issue, !sts.rd_done, "ats_dp: window read beyond count")
    `ATS_ASSERT_IMP(a_div_bound, cmd.div_step, !sts.div_done, "ats_dp: divider stepped past end")
    `ATS_ASSERT_NXT(a_count_valid, cmd.load, (n_reg != '0) && (n_reg <= fill_reg), "ats_dp: averaging count out of range")

endmodule

`default_nettype wire

### rtl/altitude_track_statistics_core.sv
// ----------------------------------------------------------------------------
// altitude_track_statistics_core
// Altitude statistics over a sample stream: windowed floor mean, min/max
// since reset and saturating ascent/descent totals with hysteresis.
// ----------------------------------------------------------------------------
// Each accepted altitude sample produces one result. The block works on one
// sample at a time: it reads the n samples averaged (at most MAX_WINDOW, one
// ring-memory read per cycle), then runs the one-bit-per-cycle divider for
// SUM_W = 25 + clog2(MAX_WINDOW + 1) steps. A finished result waits in the
// output register while the next sample is accepted. The ring memory needs
// no clearing: only entries already written are ever averaged. Write the
// configuration registers only while the block is idle; cfg_ready is always
// high.
`default_nettype none

module altitude_track_statistics_core #(
    parameter int MAX_WINDOW = 64
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [ats_pkg::ALT_W-1:0]     altitude,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [ats_pkg::ALT_W-1:0]          current_alt,
    output logic signed [ats_pkg::ALT_W-1:0]          mean_alt,
    output logic signed [ats_pkg::ALT_W-1:0]          lowest_alt,
    output logic signed [ats_pkg::ALT_W-1:0]          highest_alt,
    output logic [ats_pkg::TOTAL_W-1:0]               total_ascent,
    output logic [ats_pkg::TOTAL_W-1:0]               total_descent,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ats_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [ats_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import ats_pkg::*;

    logic [WLEN_W-1:0] window_len_reg;
    logic [HYST_W-1:0] hyst_reg;
    ats_cmd_t          cmd;
    ats_sts_t          sts;

    assign cfg_ready = 1'b1;

    // register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= WINDOW_LEN_RESET;
            hyst_reg       <= HYSTERESIS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WINDOW_LEN: window_len_reg <= cfg_data[WLEN_W-1:0];
                REG_HYSTERESIS: hyst_reg       <= cfg_data[HYST_W-1:0];
                default:        ;
            endcase
        end
    end

    ats_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ats_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .window_len    (window_len_reg),
        .hysteresis    (hyst_reg),
        .altitude      (altitude),
        .current_alt   (current_alt),
        .mean_alt      (mean_alt),
        .lowest_alt    (lowest_alt),
        .highest_alt   (highest_alt),
        .total_ascent  (total_ascent),
        .total_descent (total_descent)
    );

endmodule

`default_nettype wire
